FILE: rtl/core/sspj_pkg.sv
// Package for the sphere surface projection core: widths, config register
// indexes and the item structs handed along the square root and divide cells.
// No dependencies.
package sspj_pkg;

    localparam int CW    = 32;          // coordinate width
    localparam int MW    = CW + 1;      // magnitude of a coordinate difference
    localparam int SQW   = 2 * MW;      // width of one square
    localparam int SUMW  = SQW;         // sum of three squares stays below 2^66
    localparam int ROOTW = SUMW / 2;    // square root width, one bit per cell
    localparam int RADW  = 2 * ROOTW;   // radicand padded to an even width
    localparam int SREMW = ROOTW + 2;   // square root partial remainder
    localparam int RW    = 31;          // radius and band register width
    localparam int NUMW  = RW + CW;     // R * |d| stays below 2^63
    localparam int NLANE = 3;
    localparam int CFGIW = 3;

    // Config register indexes
    localparam logic [CFGIW-1:0] CFG_CENTRE_X = 3'd0;
    localparam logic [CFGIW-1:0] CFG_CENTRE_Y = 3'd1;
    localparam logic [CFGIW-1:0] CFG_CENTRE_Z = 3'd2;
    localparam logic [CFGIW-1:0] CFG_RADIUS   = 3'd3;
    localparam logic [CFGIW-1:0] CFG_BAND     = 3'd4;

    // Point data carried past the distance calculation
    typedef struct packed {
        logic signed [CW-1:0]    px;
        logic signed [CW-1:0]    py;
        logic signed [CW-1:0]    pz;
        logic [MW-1:0]           mx;
        logic [MW-1:0]           my;
        logic [MW-1:0]           mz;
        logic [NLANE-1:0]        neg;   // difference below zero, per axis
    } t_pass;

    // One square root cell's worth of state
    typedef struct packed {
        logic [SREMW-1:0] rem;
        logic [ROOTW-1:0] root;
        logic [RADW-1:0]  rad;
        t_pass            pass;
    } t_sq;

    // One divide lane: partial remainder, numerator bits out, quotient bits in
    typedef struct packed {
        logic [ROOTW-1:0] rem;
        logic [NUMW-1:0]  nq;
    } t_lane;

    typedef struct packed {
        t_lane [NLANE-1:0] lane;
        logic [ROOTW-1:0]  r;
        t_pass             pass;
        logic              moved;
        logic              outside;
        logic              centre;
    } t_dv;

endpackage

FILE: rtl/core/sspj_sqrt_cell.sv
// One bit of the digit by digit square root of the squared distance.
// Depends on sspj_pkg.
module sspj_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  sspj_pkg::t_sq i_d,
    output logic          o_valid,
    output sspj_pkg::t_sq o_d
);

    logic                         r_valid;
    sspj_pkg::t_sq                r_d;
    sspj_pkg::t_sq                n_d;
    logic [sspj_pkg::SREMW+1:0]   cur;
    logic [sspj_pkg::SREMW+1:0]   trial;
    logic                         take;

    // Bring down two radicand bits and try root*4+1
    always_comb begin
        cur   = {i_d.rem, i_d.rad[sspj_pkg::RADW-1 -: 2]};
        trial = {2'b00, i_d.root, 2'b01};
        take  = (cur >= trial);
        n_d        = i_d;
        n_d.rem    = take ? sspj_pkg::SREMW'(cur - trial) : cur[sspj_pkg::SREMW-1:0];
        n_d.root   = {i_d.root[sspj_pkg::ROOTW-2:0], take};
        n_d.rad    = {i_d.rad[sspj_pkg::RADW-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

FILE: rtl/core/sspj_div_cell.sv
// One quotient bit of the three restoring divisions R*|d| / r.
// Depends on sspj_pkg.
module sspj_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  sspj_pkg::t_dv i_d,
    output logic          o_valid,
    output sspj_pkg::t_dv o_d
);

    logic                       r_valid;
    sspj_pkg::t_dv              r_d;
    sspj_pkg::t_dv              n_d;
    logic [sspj_pkg::ROOTW:0]   cur [sspj_pkg::NLANE];
    logic                       take [sspj_pkg::NLANE];

    // Shift in the next numerator bit per lane and subtract when it fits
    always_comb begin
        n_d = i_d;
        for (int k = 0; k < sspj_pkg::NLANE; k++) begin
            cur[k]  = {i_d.lane[k].rem, i_d.lane[k].nq[sspj_pkg::NUMW-1]};
            take[k] = (cur[k] >= {1'b0, i_d.r});
            n_d.lane[k].rem = take[k] ? sspj_pkg::ROOTW'(cur[k] - {1'b0, i_d.r})
                                      : cur[k][sspj_pkg::ROOTW-1:0];
            n_d.lane[k].nq  = {i_d.lane[k].nq[sspj_pkg::NUMW-2:0], take[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;

endmodule

FILE: rtl/core/sphere_surface_projection_core.sv
// Top level of the sphere surface projection core: config registers,
// distance stages, square root and divide cell chains, output register.
// Depends on sspj_pkg, sspj_sqrt_cell and sspj_div_cell.
//
// Takes one point per clock while not stalled and returns one result per point,
// in order. The pipeline is a difference stage, a square stage, a sum stage,
// 33 square root cells (one root bit each), a compare and product stage, 63
// divide cells (one quotient bit each) and the output register. The whole
// pipeline holds while a result waits and i_ready is low. The user must write
// config registers with i_cfg_we only while no item is in flight; the core does not enforce it.
module sphere_surface_projection_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sspj_pkg::CFGIW-1:0]        i_cfg_idx,
    input  logic [sspj_pkg::CW-1:0]           i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [sspj_pkg::CW-1:0]    i_point_x,
    input  logic signed [sspj_pkg::CW-1:0]    i_point_y,
    input  logic signed [sspj_pkg::CW-1:0]    i_point_z,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [sspj_pkg::CW-1:0]    o_new_x,
    output logic signed [sspj_pkg::CW-1:0]    o_new_y,
    output logic signed [sspj_pkg::CW-1:0]    o_new_z,
    output logic                              o_moved,
    output logic                              o_outside_band,
    output logic                              o_at_centre
);

    localparam int CW = sspj_pkg::CW;
    localparam int MW = sspj_pkg::MW;

    // Config registers
    logic signed [CW-1:0]          r_cx, r_cy, r_cz;
    logic [sspj_pkg::RW-1:0]       r_radius, r_band;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
            r_radius <= sspj_pkg::RW'(65536);
            r_band   <= sspj_pkg::RW'(65536);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sspj_pkg::CFG_CENTRE_X: r_cx     <= i_cfg_data;
                sspj_pkg::CFG_CENTRE_Y: r_cy     <= i_cfg_data;
                sspj_pkg::CFG_CENTRE_Z: r_cz     <= i_cfg_data;
                sspj_pkg::CFG_RADIUS:   r_radius <= i_cfg_data[sspj_pkg::RW-1:0];
                sspj_pkg::CFG_BAND:     r_band   <= i_cfg_data[sspj_pkg::RW-1:0];
                default: ;
            endcase
        end
    end

    // Global advance: hold everything while a result is stalled
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // Stage 1: differences and magnitudes
    logic signed [MW-1:0] dx, dy, dz;
    sspj_pkg::t_pass      n_p1, r_p1;
    logic                 r_v1;

    always_comb begin
        dx = MW'(i_point_x) - MW'(r_cx);
        dy = MW'(i_point_y) - MW'(r_cy);
        dz = MW'(i_point_z) - MW'(r_cz);
        n_p1.px  = i_point_x;
        n_p1.py  = i_point_y;
        n_p1.pz  = i_point_z;
        n_p1.neg = {dz[MW-1], dy[MW-1], dx[MW-1]};
        n_p1.mx  = dx[MW-1] ? MW'(-dx) : MW'(dx);
        n_p1.my  = dy[MW-1] ? MW'(-dy) : MW'(dy);
        n_p1.mz  = dz[MW-1] ? MW'(-dz) : MW'(dz);
    end

    // Stage 2: squares; stage 3: sum
    logic [sspj_pkg::SQW-1:0]  r_sqx, r_sqy, r_sqz;
    sspj_pkg::t_pass           r_p2;
    logic                      r_v2;
    sspj_pkg::t_sq             sq_d [sspj_pkg::ROOTW+1];
    logic                      sq_v [sspj_pkg::ROOTW+1];
    sspj_pkg::t_sq             r_sq0;
    logic                      r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (en) begin
            r_p1  <= n_p1;
            r_sqx <= r_p1.mx * r_p1.mx;
            r_sqy <= r_p1.my * r_p1.my;
            r_sqz <= r_p1.mz * r_p1.mz;
            r_p2  <= r_p1;
            r_sq0.rem  <= '0;
            r_sq0.root <= '0;
            r_sq0.rad  <= sspj_pkg::RADW'(r_sqx + r_sqy + r_sqz);
            r_sq0.pass <= r_p2;
        end
    end

    assign sq_d[0] = r_sq0;
    assign sq_v[0] = r_v3;

    // Square root cell chain
    for (genvar g = 0; g < sspj_pkg::ROOTW; g++) begin : g_sqrt
        sspj_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[g]),
            .i_d     (sq_d[g]),
            .o_valid (sq_v[g+1]),
            .o_d     (sq_d[g+1])
        );
    end

    // Band check and numerators
    sspj_pkg::t_sq               sq_o;
    logic [sspj_pkg::ROOTW-1:0]  rr, dev;
    logic                        outside, centre;
    sspj_pkg::t_dv               n_dv0, r_dv0;
    logic                        r_vd0;

    always_comb begin
        sq_o    = sq_d[sspj_pkg::ROOTW];
        rr      = sq_o.root;
        dev     = (rr > sspj_pkg::ROOTW'(r_radius)) ? rr - sspj_pkg::ROOTW'(r_radius)
                                                    : sspj_pkg::ROOTW'(r_radius) - rr;
        outside = dev > sspj_pkg::ROOTW'(r_band);
        centre  = (rr == '0);
        n_dv0.r       = rr;
        n_dv0.pass    = sq_o.pass;
        n_dv0.outside = outside;
        n_dv0.centre  = centre;
        n_dv0.moved   = outside && !centre;
        n_dv0.lane[0].rem = '0;
        n_dv0.lane[1].rem = '0;
        n_dv0.lane[2].rem = '0;
        n_dv0.lane[0].nq  = sspj_pkg::NUMW'(r_radius * sq_o.pass.mx);
        n_dv0.lane[1].nq  = sspj_pkg::NUMW'(r_radius * sq_o.pass.my);
        n_dv0.lane[2].nq  = sspj_pkg::NUMW'(r_radius * sq_o.pass.mz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd0 <= 1'b0;
        end else if (en) begin
            r_vd0 <= sq_v[sspj_pkg::ROOTW];
        end
        if (en) begin
            r_dv0 <= n_dv0;
        end
    end

    // Divide cell chain
    sspj_pkg::t_dv dv_d [sspj_pkg::NUMW+1];
    logic          dv_v [sspj_pkg::NUMW+1];

    assign dv_d[0] = r_dv0;
    assign dv_v[0] = r_vd0;

    for (genvar g = 0; g < sspj_pkg::NUMW; g++) begin : g_div
        sspj_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[g]),
            .i_d     (dv_d[g]),
            .o_valid (dv_v[g+1]),
            .o_d     (dv_d[g+1])
        );
    end

    // Apply sign, add centre, saturate
    localparam int SUMS = sspj_pkg::NUMW + 3;
    sspj_pkg::t_dv        dv_o;
    logic signed [SUMS-1:0] sq [sspj_pkg::NLANE];
    logic signed [SUMS-1:0] sum [sspj_pkg::NLANE];
    logic signed [CW-1:0]   sat [sspj_pkg::NLANE];
    logic signed [CW-1:0]   cen [sspj_pkg::NLANE];
    logic signed [SUMS-1:0] smax, smin;

    assign smax = SUMS'(2147483647);
    assign smin = -SUMS'(64'sd2147483648);

    always_comb begin
        dv_o   = dv_d[sspj_pkg::NUMW];
        cen[0] = r_cx;
        cen[1] = r_cy;
        cen[2] = r_cz;
        for (int k = 0; k < sspj_pkg::NLANE; k++) begin
            sq[k]  = dv_o.pass.neg[k] ? -SUMS'(dv_o.lane[k].nq) : SUMS'(dv_o.lane[k].nq);
            sum[k] = SUMS'(cen[k]) + sq[k];
            if (sum[k] > smax) begin
                sat[k] = CW'(smax);
            end else if (sum[k] < smin) begin
                sat[k] = CW'(smin);
            end else begin
                sat[k] = sum[k][CW-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= dv_v[sspj_pkg::NUMW];
        end
        if (en) begin
            o_new_x        <= dv_o.moved ? sat[0] : dv_o.pass.px;
            o_new_y        <= dv_o.moved ? sat[1] : dv_o.pass.py;
            o_new_z        <= dv_o.moved ? sat[2] : dv_o.pass.pz;
            o_moved        <= dv_o.moved;
            o_outside_band <= dv_o.outside;
            o_at_centre    <= dv_o.centre;
        end
    end

`ifndef ASSERT_OFF
    a_moved_not_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_moved && o_at_centre))
        else $error("moved item flagged at centre");
    a_moved_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_moved) |-> o_outside_band)
        else $error("moved item not outside band");
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input taken while pipeline stalled");
`endif

endmodule

FILE: verif/sphere_surface_projection_checker.sv
// Checker for the sphere surface projection core: mirrors the config registers,
// predicts each accepted point's result and compares it with the output channel.
// Depends on sspj_pkg.
module sphere_surface_projection_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sspj_pkg::CFGIW-1:0]     i_cfg_idx,
    input  logic [sspj_pkg::CW-1:0]        i_cfg_data,
    input  logic                           i_valid,
    input  logic                           i_in_ready,
    input  logic signed [sspj_pkg::CW-1:0] i_point_x,
    input  logic signed [sspj_pkg::CW-1:0] i_point_y,
    input  logic signed [sspj_pkg::CW-1:0] i_point_z,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic signed [sspj_pkg::CW-1:0] i_new_x,
    input  logic signed [sspj_pkg::CW-1:0] i_new_y,
    input  logic signed [sspj_pkg::CW-1:0] i_new_z,
    input  logic                           i_moved,
    input  logic                           i_outside_band,
    input  logic                           i_at_centre,
    output int                             o_errors,
    output int                             o_pending
);
    import sspj_pkg::*;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 moved;
        logic                 outside;
        logic                 centre;
    } t_proj;

    logic signed [CW-1:0] ctr_x, ctr_y, ctr_z;
    logic [RW-1:0]        radius, band;
    t_proj                proj_q[$];

    assign o_pending = proj_q.size();

    // Floor square root of a sum below 2^66
    function automatic logic [33:0] dist_root(logic [67:0] sum);
        logic [33:0] root;
        logic [67:0] cand;
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = {34'd0, root | (34'd1 << b)};
            if (cand * cand <= sum) root = cand[33:0];
        end
        return root;
    endfunction

    // c + (R*d)/r, truncated toward zero, saturated to 32 bits
    function automatic logic signed [CW-1:0] axis_project(longint c, longint d,
                                                         logic [RW-1:0] rad,
                                                         logic [33:0] r);
        longint unsigned num, q;
        longint s;
        num = longint'(rad) * longint'(d < 0 ? -d : d);
        q = num / longint'(r);
        s = (d < 0) ? c - longint'(q) : c + longint'(q);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[CW-1:0];
    endfunction

    function automatic t_proj project_point(logic signed [CW-1:0] px,
                                            logic signed [CW-1:0] py,
                                            logic signed [CW-1:0] pz);
        t_proj  res;
        longint dx, dy, dz, dev;
        logic [67:0] mx, my, mz;
        logic [33:0] r;
        dx = longint'(px) - longint'(ctr_x);
        dy = longint'(py) - longint'(ctr_y);
        dz = longint'(pz) - longint'(ctr_z);
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        mz = (dz < 0) ? -dz : dz;
        r = dist_root(mx * mx + my * my + mz * mz);
        dev = longint'(r) - longint'(radius);
        if (dev < 0) dev = -dev;
        res.outside = dev > longint'(band);
        res.centre  = (r == 0);
        res.moved   = res.outside && !res.centre;
        if (res.moved) begin
            res.x = axis_project(ctr_x, dx, radius, r);
            res.y = axis_project(ctr_y, dy, radius, r);
            res.z = axis_project(ctr_z, dz, radius, r);
        end else begin
            res.x = px;
            res.y = py;
            res.z = pz;
        end
        return res;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    // Config mirror, prediction on input items, compare on output items
    always @(posedge i_clk) begin
        t_proj want;
        if (!i_rst_n) begin
            ctr_x  <= '0;
            ctr_y  <= '0;
            ctr_z  <= '0;
            radius <= 31'd65536;
            band   <= 31'd65536;
            proj_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CENTRE_X: ctr_x  <= i_cfg_data;
                    CFG_CENTRE_Y: ctr_y  <= i_cfg_data;
                    CFG_CENTRE_Z: ctr_z  <= i_cfg_data;
                    CFG_RADIUS:   radius <= i_cfg_data[RW-1:0];
                    CFG_BAND:     band   <= i_cfg_data[RW-1:0];
                    default: ;
                endcase
            end
            if (i_valid && i_in_ready)
                proj_q.push_back(project_point(i_point_x, i_point_y, i_point_z));
            if (i_out_valid && i_out_ready) begin
                if (proj_q.size() == 0) begin
                    report("unexpected item", 0, 0);
                end else begin
                    want = proj_q.pop_front();
                    if (i_new_x !== want.x) report("new_x", i_new_x, want.x);
                    if (i_new_y !== want.y) report("new_y", i_new_y, want.y);
                    if (i_new_z !== want.z) report("new_z", i_new_z, want.z);
                    if (i_moved !== want.moved) report("moved", i_moved, want.moved);
                    if (i_outside_band !== want.outside)
                        report("outside_band", i_outside_band, want.outside);
                    if (i_at_centre !== want.centre)
                        report("at_centre", i_at_centre, want.centre);
                end
            end
        end
    end

endmodule

FILE: verif/sphere_surface_projection_core_tb.sv
// Testbench top for the sphere surface projection core: clock, reset, config
// phases and point stimulus with random idling. Depends on sspj_pkg, the core
// and sphere_surface_projection_checker.
module sphere_surface_projection_core_tb;
    import sspj_pkg::*;

    localparam logic [CFGIW-1:0] CFG_UNUSED = 3'd5;
    localparam int DRAIN = 120;
    localparam int LIMIT = 400000;
    localparam logic signed [CW-1:0] CMAX = 32'sh7FFFFFFF;
    localparam logic signed [CW-1:0] CMIN = 32'sh80000000;

    logic                 i_clk, i_rst_n;
    logic                 cfg_we;
    logic [CFGIW-1:0]     cfg_idx;
    logic [CW-1:0]        cfg_data;
    logic                 in_valid, in_ready, out_valid, out_ready;
    logic signed [CW-1:0] pt_x, pt_y, pt_z, new_x, new_y, new_z;
    logic                 moved, outside_band, at_centre;
    int                   errors, pending, cycles;
    int                   send_idle, recv_idle;
    logic                 hold_req;
    logic signed [CW-1:0] cx, cy, cz;
    logic [RW-1:0]        rad;

    sphere_surface_projection_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_point_x(pt_x), .i_point_y(pt_y), .i_point_z(pt_z),
        .o_valid(out_valid), .i_ready(out_ready),
        .o_new_x(new_x), .o_new_y(new_y), .o_new_z(new_z),
        .o_moved(moved), .o_outside_band(outside_band), .o_at_centre(at_centre)
    );

    sphere_surface_projection_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_in_ready(in_ready),
        .i_point_x(pt_x), .i_point_y(pt_y), .i_point_z(pt_z),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_new_x(new_x), .i_new_y(new_y), .i_new_z(new_z),
        .i_moved(moved), .i_outside_band(outside_band), .i_at_centre(at_centre),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Timeout guard
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // One register write; the caller drops cfg_we after the last one
    task automatic cfg_write(logic [CFGIW-1:0] idx, logic [CW-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Wait for the pipeline to empty before touching config
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_sphere(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                              logic signed [CW-1:0] z, logic [RW-1:0] r,
                              logic [RW-1:0] b);
        drain();
        cfg_write(CFG_CENTRE_X, x);
        cfg_write(CFG_CENTRE_Y, y);
        cfg_write(CFG_CENTRE_Z, z);
        cfg_write(CFG_RADIUS, {1'b0, r});
        cfg_write(CFG_BAND, {1'b0, b});
        cfg_we <= 1'b0;
        cx = x; cy = y; cz = z; rad = r;
    endtask

    task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                              logic signed [CW-1:0] z);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        pt_x <= x;
        pt_y <= y;
        pt_z <= z;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Random point: full range, near the sphere, near the centre, at it, or at the extreme corners
    task automatic send_random();
        logic signed [CW-1:0] x, y, z;
        int sel;
        logic [CW-1:0] off;
        sel = $urandom_range(9);
        x = $urandom; y = $urandom; z = $urandom;
        case (sel)
            0, 1, 2: ;
            3, 4, 5: begin
                // axis-aligned, distance close to the radius
                off = $urandom_range(2 * 65536);
                x = cx + $signed(rad) + $signed(off) - 65536;
                y = cy + $signed($urandom_range(512)) - 256;
                z = cz;
                if ($urandom_range(1)) begin
                    x = cy + y - cy;
                    y = cy - $signed(rad) - $signed(off) + 65536;
                    x = cx + $signed($urandom_range(512)) - 256;
                end
            end
            6, 7: begin
                x = cx + $signed($urandom_range(8 * 65536)) - 4 * 65536;
                y = cy + $signed($urandom_range(8 * 65536)) - 4 * 65536;
                z = cz + $signed($urandom_range(8 * 65536)) - 4 * 65536;
            end
            8: begin
                x = cx; y = cy; z = cz;
            end
            default: begin
                x = $urandom_range(1) ? CMAX : CMIN;
                y = $urandom_range(1) ? CMAX : CMIN;
                z = $urandom_range(1) ? CMAX : CMIN;
            end
        endcase
        send_point(x, y, z);
    endtask

    initial begin
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_CENTRE_X;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pt_x = '0; pt_y = '0; pt_z = '0;
        hold_req  = 1'b0;
        send_idle = 24;
        recv_idle = 68;
        cx = '0; cy = '0; cz = '0; rad = 31'd65536;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config, centre case, sphere, band edges, extremes
        send_point(0, 0, 0);
        send_point(32'sd65536, 0, 0);
        send_point(32'sd131072, 0, 0);
        send_point(32'sd131073, 0, 0);
        send_point(0, 0, -32'sd200000);
        send_point(1, 0, 0);
        send_point(CMAX, CMAX, CMAX);
        send_point(CMIN, CMIN, CMIN);
        send_point(CMIN, CMAX, 0);
        send_point(-32'sd1, -32'sd1, -32'sd1);
        // Extreme centre with full radius: saturation
        set_sphere(CMAX, CMIN, CMAX, 31'h7FFFFFFF, 31'd1);
        send_point(CMIN, CMAX, CMIN);
        send_point(CMAX, CMIN, CMAX);
        send_point(CMAX - 1, CMIN, CMAX);
        send_point(0, 0, 0);
        // Zero radius and zero band
        set_sphere(32'sd1000, -32'sd1000, 0, 31'd0, 31'd0);
        send_point(32'sd1000, -32'sd1000, 0);
        send_point(32'sd5000, 32'sd7, 0);
        send_point(CMIN, CMAX, CMIN);
        // Unknown index is ignored
        drain();
        cfg_write(CFG_UNUSED, 32'hFFFFFFFF);
        cfg_we <= 1'b0;
        send_point(32'sd1001, -32'sd1000, 0);
        send_point(CMAX, CMAX, CMAX);

        // Random phases across settings, cycling idle mode
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_sphere(0, 0, 0, 31'd65536, 31'd65536);
                1: set_sphere($urandom, $urandom, 0, RW'($urandom_range(1 << 24, 1)),
                              RW'($urandom_range(4096, 1)));
                2: set_sphere(CMIN, CMIN, CMIN, 31'h7FFFFFFF, 31'h7FFFFFFF);
                3: set_sphere($urandom, $urandom, $urandom,
                              RW'($urandom_range(1 << 22, 1 << 16)), 31'd1);
                4: set_sphere($urandom_range(1 << 20), 0, 0, 31'd0, 31'd0);
                default: set_sphere($urandom, $urandom, $urandom, RW'($urandom),
                                    RW'($urandom));
            endcase
            case (ph % 3)
                0: begin send_idle = 24; recv_idle = 68; end
                1: begin send_idle = 68; recv_idle = 24; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            if (ph == 2) hold_req <= 1'b1;
            for (int n = 0; n < 155; n++) send_random();
        end

        drain();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
